### hdl/dhl_pkg.sv
// Package for the double-hashing table lookup/insert unit.
// Holds field widths, register map, result codes, FSM state and the
// controller/datapath command and status structs. No dependencies.
package dhl_pkg;

	localparam int DHL_DEPTH = 2048;
	localparam int DHL_KEY_W = 32;

	localparam int KEY_IN_W = 32;
	localparam int SLOT_W   = 11;
	localparam int SIZE_W   = 12;
	localparam int CAP_W    = 11;
	localparam int FILL_W   = 12;
	localparam int STAT_W   = 3;

	localparam int S_DATA_W = 56;   // key, start_slot, probe_step, zero pad
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 16;   // slot, zero pad
	localparam int M_USER_W = STAT_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY   = 3'd4;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 12'd1103;
	localparam logic [CAP_W-1:0]  CAPACITY_RST   = 11'd735;

	typedef enum logic [STAT_W-1:0] {
		RES_FOUND    = 3'd0,
		RES_INSERTED = 3'd1,
		RES_ABSENT   = 3'd2,
		RES_FULL     = 3'd3,
		RES_BAD_HASH = 3'd4
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic    clr_wr;
		logic    load;
		logic    advance;
		logic    emit;
		logic    ins_wr;
		result_t code;
	} dhl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic slot_valid;
		logic hit;
		logic last;
		logic room;
		logic insert;
		logic out_free;
	} dhl_sts_t;

endpackage

### hdl/dhl_cfg.sv
// APB register block: table_size and capacity.
// Depends on dhl_pkg for the register map and reset values.
module dhl_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dhl_pkg::APB_AW-1:0]  paddr,
	input  logic [dhl_pkg::APB_DW-1:0]  pwdata,
	output logic [dhl_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [dhl_pkg::SIZE_W-1:0]  table_size,
	output logic [dhl_pkg::CAP_W-1:0]   capacity
);
	import dhl_pkg::*;

	logic                wr_en;
	logic [SIZE_W-1:0]   size_q;
	logic [CAP_W-1:0]    cap_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= TABLE_SIZE_RST;
			cap_q  <= CAPACITY_RST;
		end else if (wr_en) begin
			if (paddr == ADDR_TABLE_SIZE) begin
				size_q <= pwdata[SIZE_W-1:0];
			end
			if (paddr == ADDR_CAPACITY) begin
				cap_q <= pwdata[CAP_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_TABLE_SIZE) begin
			prdata = {{(APB_DW-SIZE_W){1'b0}}, size_q};
		end else if (paddr == ADDR_CAPACITY) begin
			prdata = {{(APB_DW-CAP_W){1'b0}}, cap_q};
		end
	end

	assign table_size = size_q;
	assign capacity   = cap_q;

endmodule

### hdl/dhl_ctrl.sv
// Controller FSM: clearing pass, request accept, probe decisions.
// Depends on dhl_pkg for state, result codes and command/status structs.
module dhl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  dhl_pkg::dhl_sts_t  sts,
	output dhl_pkg::dhl_cmd_t  cmd
);
	import dhl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.load) state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (cmd.emit) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		logic fin;
		logic wr;
		fin      = 1'b0;
		wr       = 1'b0;
		cmd      = '0;
		cmd.code = RES_FOUND;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_PROBE: begin
				priority if (sts.bad) begin
					cmd.code = RES_BAD_HASH;
					fin      = 1'b1;
				end else if (!sts.slot_valid) begin
					fin = 1'b1;
					priority if (!sts.insert) begin
						cmd.code = RES_ABSENT;
					end else if (!sts.room) begin
						cmd.code = RES_FULL;
					end else begin
						cmd.code = RES_INSERTED;
						wr       = 1'b1;
					end
				end else if (sts.hit) begin
					cmd.code = RES_FOUND;
					fin      = 1'b1;
				end else if (sts.last) begin
					// every slot probed without a match or a hole
					cmd.code = sts.insert ? RES_FULL : RES_ABSENT;
					fin      = 1'b1;
				end else begin
					cmd.advance = 1'b1;
				end
				// hold the decision until the output register frees up
				cmd.emit   = fin & sts.out_free;
				cmd.ins_wr = wr & sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

### hdl/dhl_dp.sv
// Datapath: request registers, probe position adder, slot memory with
// valid bit, fill counter, clear sweep counter and output register.
// Depends on dhl_pkg for widths, result codes and command/status structs.
module dhl_dp #(
	parameter int DEPTH = dhl_pkg::DHL_DEPTH,
	parameter int KEY_W = dhl_pkg::DHL_KEY_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dhl_pkg::dhl_cmd_t            cmd,
	output dhl_pkg::dhl_sts_t            sts,
	input  logic [dhl_pkg::SIZE_W-1:0]   table_size,
	input  logic [dhl_pkg::CAP_W-1:0]    capacity,
	input  logic [dhl_pkg::KEY_IN_W-1:0] in_key,
	input  logic [dhl_pkg::SLOT_W-1:0]   in_start_slot,
	input  logic [dhl_pkg::SLOT_W-1:0]   in_probe_step,
	input  logic                         in_insert,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [dhl_pkg::STAT_W-1:0]   out_status,
	output logic [dhl_pkg::SLOT_W-1:0]   out_slot
);
	import dhl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [KEY_W:0]      mem [DEPTH];   // {valid, key}
	logic [KEY_W:0]      rd_q;

	logic [KEY_W-1:0]    key_q;
	logic [SIZE_W-1:0]   pos_q;
	logic [SLOT_W-1:0]   step_q;
	logic                insert_q;
	logic                bad_q;
	logic [SIZE_W-1:0]   cnt_q;
	logic [FILL_W-1:0]   fill_q;
	logic [AW-1:0]       clr_q;

	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;

	logic [SIZE_W:0]     pos_sum;
	logic [SIZE_W:0]     pos_wrap;
	logic [SIZE_W-1:0]   pos_next;
	logic                bad_in;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [KEY_W:0]      mem_wd;
	logic                mem_re;
	logic [AW-1:0]       mem_ra;

	// next probe position: one add, one conditional subtract of table_size
	assign pos_sum  = {1'b0, pos_q} + {{(SIZE_W+1-SLOT_W){1'b0}}, step_q};
	assign pos_wrap = pos_sum - {1'b0, table_size};
	assign pos_next = (pos_sum >= {1'b0, table_size}) ? pos_wrap[SIZE_W-1:0]
	                                                  : pos_sum[SIZE_W-1:0];

	assign bad_in = (table_size < SIZE_W'(2))
	             || (32'(table_size) > 32'(DEPTH))
	             || ({1'b0, in_start_slot} >= table_size)
	             || (in_probe_step == '0)
	             || ({1'b0, in_probe_step} >= table_size);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= KEY_W'(in_key);
			pos_q    <= {{(SIZE_W-SLOT_W){1'b0}}, in_start_slot};
			step_q   <= in_probe_step;
			insert_q <= in_insert;
			bad_q    <= bad_in;
			cnt_q    <= SIZE_W'(1);
		end else if (cmd.advance) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.ins_wr) fill_q <= fill_q + FILL_W'(1);
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
		end
	end

	// slot memory: one write port, one registered read port
	assign mem_we = cmd.clr_wr | cmd.ins_wr;
	assign mem_wa = cmd.clr_wr ? clr_q : AW'(pos_q);
	assign mem_wd = cmd.clr_wr ? '0 : {1'b1, key_q};
	assign mem_re = cmd.load | cmd.advance;
	assign mem_ra = cmd.load ? AW'(in_start_slot) : AW'(pos_next);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.code;
			out_slot_q   <= pos_q[SLOT_W-1:0];
		end
	end

	assign sts.clr_last   = (clr_q == AW'(DEPTH - 1));
	assign sts.bad        = bad_q;
	assign sts.slot_valid = rd_q[KEY_W];
	assign sts.hit        = (rd_q[KEY_W-1:0] == key_q);
	assign sts.last       = (cnt_q == table_size);
	assign sts.room       = ({{(FILL_W-CAP_W){1'b0}}, capacity} > fill_q);
	assign sts.insert     = insert_q;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid   = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("result loaded over a pending result");

	a_ins_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (!rd_q[KEY_W] && (fill_q < {{(FILL_W-CAP_W){1'b0}}, capacity})))
		else $error("insert into occupied slot or beyond capacity");

	a_adv_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (rd_q[KEY_W] && (rd_q[KEY_W-1:0] != key_q) && !bad_q))
		else $error("probe advanced past a hit or an empty slot");

	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.load || cmd.advance || cmd.emit || cmd.ins_wr))
		else $error("request activity during clearing pass");

endmodule

### hdl/double_hash_table_lookup_insert_unit.sv
// Top level of the double-hashing table lookup/insert unit.
// Depends on dhl_pkg, dhl_cfg, dhl_ctrl and dhl_dp.
//
//  channel   dir  handshake            payload
//  apb       in   psel/penable/pready  paddr, pwdata (write), prdata (read)
//  s_axis    in   s_tvalid/s_tready    s_tdata: key, start_slot, probe_step; s_tuser: insert
//  m_axis    out  m_tvalid/m_tready    m_tdata: slot; m_tuser: status
//
// After reset a clearing pass writes every slot empty, with
// s_tready low; register writes are taken during it.
// A request is accepted in ST_IDLE, which reads its start slot, then probed
// one slot at a time; a bad hash or bad table size ends at the first decision.
// The probe loop is bound by the single read port of the slot memory.
// A finished result waits in the output register; the next request is
// accepted meanwhile and only its decision stalls while m_tready is low.
module double_hash_table_lookup_insert_unit #(
	parameter int DEPTH = dhl_pkg::DHL_DEPTH,
	parameter int KEY_W = dhl_pkg::DHL_KEY_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dhl_pkg::APB_AW-1:0]    paddr,
	input  logic [dhl_pkg::APB_DW-1:0]    pwdata,
	output logic [dhl_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dhl_pkg::S_DATA_W-1:0]  s_tdata,  // key[31:0], start_slot[42:32],
	                                                // probe_step[53:43], zero pad
	input  logic [dhl_pkg::S_USER_W-1:0]  s_tuser,  // insert_if_absent[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dhl_pkg::M_DATA_W-1:0]  m_tdata,  // slot[10:0], zero pad
	output logic [dhl_pkg::M_USER_W-1:0]  m_tuser   // status[2:0]
);
	import dhl_pkg::*;

	localparam int START_LO = KEY_IN_W;
	localparam int STEP_LO  = KEY_IN_W + SLOT_W;

	logic [SIZE_W-1:0] table_size;
	logic [CAP_W-1:0]  capacity;
	dhl_cmd_t          cmd;
	dhl_sts_t          sts;
	logic [SLOT_W-1:0] out_slot;
	logic [STAT_W-1:0] out_status;

	dhl_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.table_size (table_size),
		.capacity   (capacity)
	);

	dhl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhl_dp #(
		.DEPTH (DEPTH),
		.KEY_W (KEY_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.table_size    (table_size),
		.capacity      (capacity),
		.in_key        (s_tdata[KEY_IN_W-1:0]),
		.in_start_slot (s_tdata[START_LO +: SLOT_W]),
		.in_probe_step (s_tdata[STEP_LO +: SLOT_W]),
		.in_insert     (s_tuser[0]),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_status    (out_status),
		.out_slot      (out_slot)
	);

	assign m_tdata = {{(M_DATA_W-SLOT_W){1'b0}}, out_slot};
	assign m_tuser = out_status;

endmodule
